// File: design/sacl_pkg.sv
`timescale 1ns / 1ps
package sacl_pkg;

  localparam int TAG_W   = 20;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;
  localparam int ADDR_W  = 32;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// File: design/sacl_mem.sv
`timescale 1ns / 1ps
module sacl_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 344
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/sacl_victim.sv
`timescale 1ns / 1ps
module sacl_victim #(
  parameter int NUM_WAYS = 4,
  parameter int WAY_W    = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  sacl_pkg::line_t [NUM_WAYS-1:0] row,
  output logic                          done,
  output logic [WAY_W-1:0]              way
);

  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(NUM_WAYS - 1);

  logic                         busy_r;
  logic                         done_r;
  logic [WAY_W-1:0]             idx_r;
  logic [WAY_W-1:0]             way_r;
  logic [sacl_pkg::STAMP_W-1:0] oldest_r;
  logic [sacl_pkg::STAMP_W-1:0] cur_stamp;
  logic                         take;

  // oldest stamp wins; on ties the later way wins
  assign cur_stamp = row[idx_r].stamp;
  assign take      = (cur_stamp <= oldest_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        if (idx_r == LAST_WAY) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      oldest_r <= '1;
      way_r    <= '0;
    end else if (busy_r && take) begin
      oldest_r <= cur_stamp;
      way_r    <= idx_r;
    end
  end

  assign done = done_r;
  assign way  = way_r;

endmodule

// File: design/set_assoc_cache_lru_lookup.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_address, in_operation
// out     | output    | out_valid / out_ready | out_hit, out_way_used, out_dirty_eviction,
//         |           |                       | out_*_total
//
// Hit, or miss into a free way: the set row is read, then updated and written back.
// Miss into a full set: the victim comes from the LRU stamp scan, one way per cycle.
// After reset a clearing pass writes every set row, with in_ready low. One item is in
// flight at a time; a finished item waits in the output register while the next one is taken,
// and commit waits only if that register is still full.
module set_assoc_cache_lru_lookup #(
  parameter int NUM_SETS   = 64,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_address,
  input  logic        in_operation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [1:0]  out_way_used,
  output logic        out_dirty_eviction,
  output logic [31:0] out_read_total,
  output logic [31:0] out_write_total,
  output logic [31:0] out_read_miss_total,
  output logic [31:0] out_write_miss_total,
  output logic [31:0] out_writeback_total
);

  localparam int OFF_BITS  = $clog2(LINE_BYTES + 1) - 1;
  localparam int SET_BITS  = $clog2(NUM_SETS + 1) - 1;
  localparam int SET_COUNT = 1 << SET_BITS;
  localparam int IDX_W     = (SET_BITS == 0) ? 1 : SET_BITS;
  localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ROW_W     = NUM_WAYS * $bits(sacl_pkg::line_t);
  localparam logic [IDX_W-1:0] SET_MASK = IDX_W'(SET_COUNT - 1);

  sacl_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]             clr_r;
  logic [IDX_W-1:0]             set_r;
  logic [sacl_pkg::TAG_W-1:0]   tag_r;
  logic                         store_r;
  logic [sacl_pkg::STAMP_W-1:0] acc_r;
  logic                         hit_r;
  logic [WAY_W-1:0]             way_r;

  logic [sacl_pkg::CNT_W-1:0] rd_cnt_r, wr_cnt_r, rd_miss_r, wr_miss_r, wb_cnt_r;
  logic                       out_valid_r, out_hit_r, out_dirty_r;
  logic [1:0]                 out_way_r;

  sacl_pkg::line_t [NUM_WAYS-1:0] row_q;
  sacl_pkg::line_t [NUM_WAYS-1:0] new_row;
  sacl_pkg::line_t                victim;

  logic             accept;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ROW_W-1:0] mem_wr_data;
  logic [IDX_W-1:0] in_set;

  logic             lk_hit, lk_free_found, lk_need_scan;
  logic [WAY_W-1:0] lk_hit_way, lk_free_way, lk_way;

  logic             scan_start, scan_done;
  logic [WAY_W-1:0] scan_way;

  logic             can_commit, commit;
  logic             sel_hit, evict_dirty;
  logic [WAY_W-1:0] sel_way;

  assign accept = in_valid && in_ready;
  assign in_set = IDX_W'(in_address >> OFF_BITS) & SET_MASK;

  sacl_mem #(
    .DEPTH (SET_COUNT),
    .AW    (IDX_W),
    .DW    (ROW_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (row_q)
  );

  sacl_victim #(
    .NUM_WAYS (NUM_WAYS),
    .WAY_W    (WAY_W)
  ) u_victim (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .row   (row_q),
    .done  (scan_done),
    .way   (scan_way)
  );

  // tag match and first free way
  always_comb begin
    lk_hit        = 1'b0;
    lk_hit_way    = '0;
    lk_free_found = 1'b0;
    lk_free_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_q[w].valid && (row_q[w].tag == tag_r)) begin
        lk_hit     = 1'b1;
        lk_hit_way = WAY_W'(w);
      end
      if (!row_q[w].valid) begin
        lk_free_found = 1'b1;
        lk_free_way   = WAY_W'(w);
      end
    end
    lk_way       = lk_hit ? lk_hit_way : lk_free_way;
    lk_need_scan = !lk_hit && !lk_free_found;
  end

  assign can_commit = !out_valid_r || out_ready;

  assign sel_hit = (state_r == sacl_pkg::ST_LOOKUP) ? lk_hit : hit_r;
  assign sel_way = (state_r == sacl_pkg::ST_LOOKUP) ? lk_way : way_r;
  assign victim  = row_q[sel_way];
  assign evict_dirty = !sel_hit && victim.valid && victim.dirty;

  always_comb begin
    new_row = row_q;
    if (sel_hit) begin
      new_row[sel_way].stamp = acc_r;
      new_row[sel_way].dirty = victim.dirty || store_r;
    end else begin
      new_row[sel_way].valid = 1'b1;
      new_row[sel_way].dirty = store_r;
      new_row[sel_way].tag   = tag_r;
      new_row[sel_way].stamp = acc_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        if (clr_r == SET_MASK) state_nxt = sacl_pkg::ST_IDLE;
      end
      sacl_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sacl_pkg::ST_LOOKUP;
      end
      sacl_pkg::ST_LOOKUP: begin
        if (lk_need_scan) begin
          state_nxt = sacl_pkg::ST_SCAN;
        end else if (can_commit) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end else begin
          state_nxt = sacl_pkg::ST_COMMIT;
        end
      end
      sacl_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = sacl_pkg::ST_COMMIT;
      end
      sacl_pkg::ST_COMMIT: begin
        if (can_commit) state_nxt = sacl_pkg::ST_IDLE;
      end
      default: state_nxt = sacl_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    scan_start  = 1'b0;
    commit      = 1'b0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = set_r;
    mem_wr_data = new_row;
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_r;
        mem_wr_data = '0;
      end
      sacl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      sacl_pkg::ST_LOOKUP: begin
        scan_start = lk_need_scan;
        commit     = !lk_need_scan && can_commit;
        mem_wr_en  = commit;
      end
      sacl_pkg::ST_SCAN: begin
      end
      sacl_pkg::ST_COMMIT: begin
        commit    = can_commit;
        mem_wr_en = commit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sacl_pkg::ST_CLEAR;
      clr_r       <= '0;
      acc_r       <= '0;
      rd_cnt_r    <= '0;
      wr_cnt_r    <= '0;
      rd_miss_r   <= '0;
      wr_miss_r   <= '0;
      wb_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == sacl_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (accept) acc_r <= acc_r + 1'b1;
      if (commit) begin
        out_valid_r <= 1'b1;
        if (store_r) begin
          wr_cnt_r <= sacl_pkg::sat_inc(wr_cnt_r);
          if (!sel_hit) wr_miss_r <= sacl_pkg::sat_inc(wr_miss_r);
        end else begin
          rd_cnt_r <= sacl_pkg::sat_inc(rd_cnt_r);
          if (!sel_hit) rd_miss_r <= sacl_pkg::sat_inc(rd_miss_r);
        end
        if (evict_dirty) wb_cnt_r <= sacl_pkg::sat_inc(wb_cnt_r);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_r   <= in_set;
      tag_r   <= sacl_pkg::TAG_W'(in_address >> (OFF_BITS + SET_BITS));
      store_r <= in_operation;
    end
    if (state_r == sacl_pkg::ST_LOOKUP) begin
      hit_r <= lk_hit;
      way_r <= lk_way;
    end else if (state_r == sacl_pkg::ST_SCAN && scan_done) begin
      way_r <= scan_way;
    end
    if (commit) begin
      out_hit_r   <= sel_hit;
      out_way_r   <= 2'(sel_way);
      out_dirty_r <= evict_dirty;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit              = out_hit_r;
  assign out_way_used         = out_way_r;
  assign out_dirty_eviction   = out_dirty_r;
  assign out_read_total       = rd_cnt_r;
  assign out_write_total      = wr_cnt_r;
  assign out_read_miss_total  = rd_miss_r;
  assign out_write_miss_total = wr_miss_r;
  assign out_writeback_total  = wb_cnt_r;

endmodule
